### hdl/spd_pkg.sv
package spd_pkg;

	localparam logic [7:0] HDR_FIRST    = 8'h4B;
	localparam logic [7:0] HDR_SECOND   = 8'h53;
	localparam logic [7:0] TRL_CR       = 8'h0D;
	localparam logic [7:0] TRL_LF       = 8'h0A;
	localparam logic [7:0] MIN_LENGTH   = 8'd8;
	localparam logic [7:0] HEADER_BYTES = 8'd6;

	localparam logic [7:0] POS_CMD_FIRST  = 8'd4;
	localparam logic [7:0] POS_CMD_SECOND = 8'd5;
	localparam logic [7:0] POS_DATA_TYPE  = 8'd6;
	localparam logic [7:0] POS_AFTER_LEN  = 8'd3;

	localparam logic [1:0] HIST_FULL = 2'd2;

	typedef enum logic {
		FUNC_RECEIVE = 1'b0,
		FUNC_READ    = 1'b1
	} func_t;

	typedef enum logic {
		KIND_PACKET = 1'b0,
		KIND_READ   = 1'b1
	} kind_t;

endpackage

### hdl/serial_packet_deframer_core.sv
// The result of an input transfer is registered and appears in the cycle after it.
// Throughput: one item per cycle; the output register stalls input only while
// a result waits and out_ready is low.
// Reset: arst_n asynchronous, clears framing state and output valid.
// The payload store is not cleared; unwritten entries read as undefined.
module serial_packet_deframer_core #(
	parameter int BUFFER_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       func,
	input  logic [7:0] rx_byte,
	input  logic [7:0] read_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       result_kind,
	output logic [7:0] cmd_first,
	output logic [7:0] cmd_second,
	output logic [7:0] data_type,
	output logic [7:0] total_length,
	output logic [7:0] payload_length,
	output logic [7:0] read_data
);

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	logic [7:0] older_q, newer_q;
	logic [1:0] fill_q;
	logic       active_q;
	logic [7:0] exp_len_q, count_q;
	logic [7:0] hcmd1_q, hcmd2_q, htype_q;

	logic [7:0] older_d, newer_d;
	logic [1:0] fill_d;
	logic       active_d;
	logic [7:0] exp_len_d, count_d;
	logic [7:0] hcmd1_d, hcmd2_d, htype_d;

	logic       in_acc;
	logic       res_vld;
	logic       res_kind;
	logic       wr_en;
	logic [7:0] wr_off;
	logic [7:0] pos;
	logic       is_hdr;
	logic       push;

	logic [7:0] mem [BUFFER_DEPTH];
	logic [7:0] rd_q;
	logic       rd_oor_q;

	logic       out_valid_q, out_kind_q;
	logic [7:0] out_cmd1_q, out_cmd2_q, out_type_q, out_len_q, out_plen_q;

	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	assign is_hdr = (fill_q == spd_pkg::HIST_FULL) && (older_q == spd_pkg::HDR_FIRST)
		&& (newer_q == spd_pkg::HDR_SECOND);
	assign pos    = count_q + 8'd1;
	assign wr_off = pos - (spd_pkg::HEADER_BYTES + 8'd1);

	always_comb begin
		older_d   = older_q;
		newer_d   = newer_q;
		fill_d    = fill_q;
		active_d  = active_q;
		exp_len_d = exp_len_q;
		count_d   = count_q;
		hcmd1_d   = hcmd1_q;
		hcmd2_d   = hcmd2_q;
		htype_d   = htype_q;
		res_vld   = 1'b0;
		res_kind  = spd_pkg::KIND_READ;
		wr_en     = 1'b0;
		push      = 1'b0;
		if (func == spd_pkg::FUNC_READ) begin
			res_vld  = 1'b1;
			res_kind = spd_pkg::KIND_READ;
		end else begin
			push = 1'b1;
			if (is_hdr) begin
				if (rx_byte >= spd_pkg::MIN_LENGTH) begin
					active_d  = 1'b1;
					exp_len_d = rx_byte;
					count_d   = spd_pkg::POS_AFTER_LEN;
				end else begin
					active_d = 1'b0;
				end
			end else if (active_q) begin
				count_d = pos;
				priority if (pos == spd_pkg::POS_CMD_FIRST) begin
					hcmd1_d = rx_byte;
				end else if (pos == spd_pkg::POS_CMD_SECOND) begin
					hcmd2_d = rx_byte;
				end else if (pos == spd_pkg::POS_DATA_TYPE) begin
					htype_d = rx_byte;
				end else if (({1'b0, pos} + 9'd2) <= {1'b0, exp_len_q}) begin
					wr_en = ({1'b0, wr_off} < 9'(BUFFER_DEPTH));
				end
				if (pos == exp_len_q) begin
					active_d = 1'b0;
					if (newer_q == spd_pkg::TRL_CR && rx_byte == spd_pkg::TRL_LF) begin
						res_vld   = 1'b1;
						res_kind  = spd_pkg::KIND_PACKET;
						push      = 1'b0;
						older_d   = 8'd0;
						newer_d   = 8'd0;
						fill_d    = 2'd0;
						count_d   = 8'd0;
						exp_len_d = 8'd0;
					end
				end
			end
			if (push) begin
				older_d = newer_q;
				newer_d = rx_byte;
				if (fill_q < spd_pkg::HIST_FULL) begin
					fill_d = fill_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q   <= 8'd0;
			newer_q   <= 8'd0;
			fill_q    <= 2'd0;
			active_q  <= 1'b0;
			exp_len_q <= 8'd0;
			count_q   <= 8'd0;
			hcmd1_q   <= 8'd0;
			hcmd2_q   <= 8'd0;
			htype_q   <= 8'd0;
		end else if (in_acc) begin
			older_q   <= older_d;
			newer_q   <= newer_d;
			fill_q    <= fill_d;
			active_q  <= active_d;
			exp_len_q <= exp_len_d;
			count_q   <= count_d;
			hcmd1_q   <= hcmd1_d;
			hcmd2_q   <= hcmd2_d;
			htype_q   <= htype_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && wr_en) begin
			mem[wr_off[AW-1:0]] <= rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_q     <= mem[read_index[AW-1:0]];
			rd_oor_q <= ({1'b0, read_index} >= 9'(BUFFER_DEPTH));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= res_vld;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// packet fields are zero in a read result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_kind_q <= res_kind;
			if (res_kind == spd_pkg::KIND_PACKET) begin
				out_cmd1_q <= hcmd1_q;
				out_cmd2_q <= hcmd2_q;
				out_type_q <= htype_q;
				out_len_q  <= exp_len_q;
				out_plen_q <= exp_len_q - spd_pkg::MIN_LENGTH;
			end else begin
				out_cmd1_q <= 8'd0;
				out_cmd2_q <= 8'd0;
				out_type_q <= 8'd0;
				out_len_q  <= 8'd0;
				out_plen_q <= 8'd0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = out_kind_q;
	assign cmd_first      = out_cmd1_q;
	assign cmd_second     = out_cmd2_q;
	assign data_type      = out_type_q;
	assign total_length   = out_len_q;
	assign payload_length = out_plen_q;
	assign read_data      = (out_kind_q == spd_pkg::KIND_READ && !rd_oor_q) ? rd_q : 8'd0;

endmodule

### hdl/spd_checker.sv
module spd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       func,
	input logic       out_valid,
	input logic       out_ready,
	input logic       result_kind,
	input logic [7:0] cmd_first,
	input logic [7:0] cmd_second,
	input logic [7:0] data_type,
	input logic [7:0] total_length,
	input logic [7:0] payload_length,
	input logic [7:0] read_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind)
			&& $stable(total_length) && $stable(read_data))
		else $error("stalled result changed");

	a_read_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == spd_pkg::FUNC_READ
			|=> out_valid && result_kind == spd_pkg::KIND_READ)
		else $error("read transfer gave no read result");

	a_pkt_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == spd_pkg::KIND_PACKET
			|-> total_length >= spd_pkg::MIN_LENGTH
			&& payload_length == total_length - spd_pkg::MIN_LENGTH && read_data == 8'd0)
		else $error("bad packet result fields");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == spd_pkg::KIND_READ
			|-> cmd_first == 8'd0 && cmd_second == 8'd0 && data_type == 8'd0
			&& total_length == 8'd0 && payload_length == 8'd0)
		else $error("read result carries packet fields");

endmodule

bind serial_packet_deframer_core spd_checker u_spd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.func           (func),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.result_kind    (result_kind),
	.cmd_first      (cmd_first),
	.cmd_second     (cmd_second),
	.data_type      (data_type),
	.total_length   (total_length),
	.payload_length (payload_length),
	.read_data      (read_data)
);

### test/tb.sv
module tb;

	localparam int DEPTH = 256;
	localparam int ITEMS = 1550;
	localparam int HOLD_CYCLES = 300;
	localparam int LIMIT = 400000;

	typedef struct {
		spd_pkg::func_t f;
		logic [7:0]     b;
		logic [7:0]     idx;
	} stream_item_t;

	typedef struct {
		spd_pkg::kind_t kind;
		logic [7:0]     cmd_first;
		logic [7:0]     cmd_second;
		logic [7:0]     data_type;
		logic [7:0]     total_length;
		logic [7:0]     payload_length;
		logic [7:0]     read_data;
	} report_t;

	typedef struct {
		logic [7:0] older;
		logic [7:0] newer;
		logic [1:0] fill;
		bit         active;
		logic [7:0] flen;
		logic [7:0] count;
		logic [7:0] c1;
		logic [7:0] c2;
		logic [7:0] dtype;
		logic [7:0] store [DEPTH];
		bit         written [DEPTH];
		int         nwritten;
	} deframer_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       func = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic [7:0] read_index = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       result_kind;
	logic [7:0] cmd_first;
	logic [7:0] cmd_second;
	logic [7:0] data_type;
	logic [7:0] total_length;
	logic [7:0] payload_length;
	logic [7:0] read_data;

	stream_item_t stream_q[$];
	report_t      report_q[$];
	deframer_t    plan_st;
	deframer_t    live_st;
	int           stream_count = 0;
	int           mismatches = 0;
	int           cycle_count = 0;
	int           hold_asks = 0;
	int           hold_seen = 0;
	int           hold_left = 0;
	int           burst_left = 0;
	int           gap_left = 0;
	int           rx_mode = 0;
	int           rx_mode_left = 0;
	int           rx_tick = 0;
	bit           pressed = 1'b0;
	int           pick;

	stream_item_t drv_item;
	report_t      drv_rep;
	bit           drv_got;
	logic         drv_valid;
	logic         rdy;
	report_t      mon_rep;

	serial_packet_deframer_core #(.BUFFER_DEPTH(DEPTH)) dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void clear_state(output deframer_t s);
		s.older = '0;
		s.newer = '0;
		s.fill = '0;
		s.active = 1'b0;
		s.flen = '0;
		s.count = '0;
		s.c1 = '0;
		s.c2 = '0;
		s.dtype = '0;
		s.nwritten = 0;
		for (int i = 0; i < DEPTH; i++) begin
			s.store[i] = '0;
			s.written[i] = 1'b0;
		end
	endfunction

	// one stream item through the deframer; returns 1 when a report is produced
	function automatic bit deframe(inout deframer_t s, input stream_item_t it,
		output report_t r);
		int off;
		r.kind = spd_pkg::KIND_PACKET;
		r.cmd_first = '0;
		r.cmd_second = '0;
		r.data_type = '0;
		r.total_length = '0;
		r.payload_length = '0;
		r.read_data = '0;
		if (it.f == spd_pkg::FUNC_READ) begin
			r.kind = spd_pkg::KIND_READ;
			if (int'(it.idx) < DEPTH)
				r.read_data = s.store[it.idx];
			return 1'b1;
		end
		if (s.fill == spd_pkg::HIST_FULL && s.older == spd_pkg::HDR_FIRST
			&& s.newer == spd_pkg::HDR_SECOND) begin
			if (it.b >= spd_pkg::MIN_LENGTH) begin
				s.active = 1'b1;
				s.flen = it.b;
				s.count = spd_pkg::POS_AFTER_LEN;
			end else begin
				s.active = 1'b0;
			end
		end else if (s.active) begin
			s.count = s.count + 8'd1;
			if (s.count == spd_pkg::POS_CMD_FIRST) begin
				s.c1 = it.b;
			end else if (s.count == spd_pkg::POS_CMD_SECOND) begin
				s.c2 = it.b;
			end else if (s.count == spd_pkg::POS_DATA_TYPE) begin
				s.dtype = it.b;
			end else if (int'(s.count) + 2 <= int'(s.flen)) begin
				off = int'(s.count) - int'(spd_pkg::HEADER_BYTES) - 1;
				if (off < DEPTH) begin
					if (!s.written[off])
						s.nwritten++;
					s.written[off] = 1'b1;
					s.store[off] = it.b;
				end
			end
			if (s.count == s.flen) begin
				s.active = 1'b0;
				if (s.newer == spd_pkg::TRL_CR && it.b == spd_pkg::TRL_LF) begin
					r.cmd_first = s.c1;
					r.cmd_second = s.c2;
					r.data_type = s.dtype;
					r.total_length = s.flen;
					r.payload_length = s.flen - spd_pkg::MIN_LENGTH;
					s.older = '0;
					s.newer = '0;
					s.fill = '0;
					s.count = '0;
					s.flen = '0;
					return 1'b1;
				end
			end
		end
		s.older = s.newer;
		s.newer = it.b;
		if (s.fill < spd_pkg::HIST_FULL)
			s.fill = s.fill + 2'd1;
		return 1'b0;
	endfunction

	task automatic put(spd_pkg::func_t f, logic [7:0] b, logic [7:0] idx);
		stream_item_t it;
		report_t r;
		it.f = f;
		it.b = b;
		it.idx = idx;
		void'(deframe(plan_st, it, r));
		stream_q.push_back(it);
		stream_count++;
	endtask

	task automatic put_byte(logic [7:0] b);
		put(spd_pkg::FUNC_RECEIVE, b, 8'($urandom_range(0, 255)));
	endtask

	// only entries already written are ever read
	task automatic put_read();
		int idx;
		if (plan_st.nwritten == 0)
			return;
		do
			idx = $urandom_range(0, DEPTH - 1);
		while (!plan_st.written[idx]);
		put(spd_pkg::FUNC_READ, 8'($urandom_range(0, 255)), 8'(idx));
	endtask

	task automatic put_frame(logic [7:0] len, logic [7:0] c1, logic [7:0] c2,
		logic [7:0] dt, bit good);
		put_byte(spd_pkg::HDR_FIRST);
		put_byte(spd_pkg::HDR_SECOND);
		put_byte(len);
		put_byte(c1);
		put_byte(c2);
		put_byte(dt);
		repeat (int'(len) - int'(spd_pkg::MIN_LENGTH))
			put_byte(8'($urandom_range(0, 255)));
		if (good) begin
			put_byte(spd_pkg::TRL_CR);
			put_byte(spd_pkg::TRL_LF);
		end else if ($urandom_range(0, 1)) begin
			put_byte(spd_pkg::TRL_CR);
			put_byte(spd_pkg::TRL_LF ^ 8'($urandom_range(1, 255)));
		end else begin
			put_byte(spd_pkg::TRL_CR ^ 8'($urandom_range(1, 255)));
			put_byte(spd_pkg::TRL_LF);
		end
	endtask

	function automatic logic [7:0] pick_len();
		if ($urandom_range(0, 19) == 0)
			return 8'($urandom_range(200, 255));
		return 8'($urandom_range(8, 24));
	endfunction

	// checked away from the active edge so queue and handshake state are settled
	task automatic drain();
		do
			@(negedge clk);
		while (stream_q.size() != 0 || in_valid || report_q.size() != 0);
	endtask

	task automatic check_field(string name, logic [7:0] e, logic [7:0] a);
		if (a !== e) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
			mismatches++;
		end
	endtask

	initial begin
		clear_state(plan_st);
		clear_state(live_st);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: min length frame, short length, payload reads,
		// restart inside a frame followed by a bad trailer
		put_frame(spd_pkg::MIN_LENGTH, 8'hFF, 8'h00, 8'hFF, 1'b1);
		put_byte(spd_pkg::HDR_FIRST);
		put_byte(spd_pkg::HDR_SECOND);
		put_byte(spd_pkg::MIN_LENGTH - 8'd1);
		put_byte(spd_pkg::HDR_FIRST);
		put_byte(spd_pkg::HDR_SECOND);
		put_byte(8'd10);
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(8'h5A);
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(spd_pkg::TRL_CR);
		put_byte(spd_pkg::TRL_LF);
		put(spd_pkg::FUNC_READ, 8'hFF, 8'd0);
		put(spd_pkg::FUNC_READ, 8'h00, 8'd1);
		put_byte(spd_pkg::HDR_FIRST);
		put_byte(spd_pkg::HDR_SECOND);
		put_byte(8'd9);
		put_frame(spd_pkg::MIN_LENGTH, 8'h12, 8'h34, 8'h56, 1'b0);
		drain();

		put_frame(8'd255, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 1'b1);
		put(spd_pkg::FUNC_READ, 8'h00, 8'd246);
		put(spd_pkg::FUNC_READ, 8'hFF, 8'd128);
		put(spd_pkg::FUNC_READ, 8'h00, 8'd127);

		while (stream_count < ITEMS) begin
			if (!pressed && stream_count > ITEMS / 2) begin
				pressed = 1'b1;
				drain();
				repeat (40)
					put_read();
				@(negedge clk);
				hold_asks++;
				drain();
			end
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				put_frame(pick_len(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'b1);
			end else if (pick < 55) begin
				put_frame(pick_len(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'b0);
			end else if (pick < 63) begin
				put_byte(spd_pkg::HDR_FIRST);
				put_byte(spd_pkg::HDR_SECOND);
				put_byte(pick_len());
				repeat ($urandom_range(0, 12))
					put_byte(8'($urandom_range(0, 255)));
			end else if (pick < 68) begin
				put_byte(spd_pkg::HDR_FIRST);
				put_byte(spd_pkg::HDR_SECOND);
				put_byte(8'($urandom_range(0, int'(spd_pkg::MIN_LENGTH) - 1)));
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(0, 5))
						0: put_byte(spd_pkg::HDR_FIRST);
						1: put_byte(spd_pkg::HDR_SECOND);
						2: put_byte(spd_pkg::TRL_CR);
						3: put_byte(spd_pkg::TRL_LF);
						default: put_byte(8'($urandom_range(0, 255)));
					endcase
				end
			end else begin
				repeat ($urandom_range(1, 4))
					put_read();
			end
		end

		drain();
		repeat (5) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// sender: bursts with random gaps, predicts on each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= spd_pkg::FUNC_RECEIVE;
			rx_byte <= 8'h00;
			read_index <= 8'h00;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				drv_item.f = spd_pkg::func_t'(func);
				drv_item.b = rx_byte;
				drv_item.idx = read_index;
				drv_got = deframe(live_st, drv_item, drv_rep);
				if (drv_got)
					report_q.push_back(drv_rep);
			end
			if (!in_valid || in_ready) begin
				drv_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (stream_q.size() > 0) begin
					drv_item = stream_q.pop_front();
					func <= drv_item.f;
					rx_byte <= drv_item.b;
					read_index <= drv_item.idx;
					drv_valid = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
				in_valid <= drv_valid;
			end
		end
	end

	// receiver: switches among random stall patterns; long hold on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			rdy = 1'b1;
			rx_tick = (rx_tick + 1) % 3;
			if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
				rdy = 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				if (rx_mode_left == 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_mode_left = $urandom_range(20, 120);
				end else begin
					rx_mode_left--;
				end
				case (rx_mode)
					0: rdy = 1'b1;
					1: rdy = 1'($urandom_range(0, 1));
					2: rdy = (rx_tick == 0);
					default: rdy = ($urandom_range(0, 7) == 0);
				endcase
			end
			out_ready <= rdy;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (report_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0h", $time,
					result_kind);
				mismatches++;
			end else begin
				mon_rep = report_q.pop_front();
				check_field("result_kind", 8'(mon_rep.kind), 8'(result_kind));
				check_field("cmd_first", mon_rep.cmd_first, cmd_first);
				check_field("cmd_second", mon_rep.cmd_second, cmd_second);
				check_field("data_type", mon_rep.data_type, data_type);
				check_field("total_length", mon_rep.total_length, total_length);
				check_field("payload_length", mon_rep.payload_length, payload_length);
				check_field("read_data", mon_rep.read_data, read_data);
			end
		end
	end

endmodule
